// ===== design/tpm_pkg.sv =====
// shared types and constants for the timestamp pair matcher
`timescale 1ns / 1ps
package tpm_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		OP_PUSH_A = 2'd0,
		OP_PUSH_B = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_SHL
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] data;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} cell_t;

	// what a cell tells its right-hand neighbour during an insert
	typedef struct packed {
		cell_t slot;
		logic  gt;
		logic  open;
	} link_t;

endpackage

// ===== design/tpm_cell.sv =====
// one queue cell: holds an entry, inserts in order or shifts left
`timescale 1ns / 1ps
module tpm_cell import tpm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  entry_t   new_ent,
	input  link_t    prev,
	input  cell_t    next,
	output link_t    self
);

	logic   valid_q;
	entry_t ent_q;
	cell_t  cur;
	cell_t  cell_d;

	always_comb begin
		cur.valid = valid_q;
		cur.ent   = ent_q;
	end

	always_comb begin
		self.slot = cur;
		self.gt   = cur.valid && (cur.ent.stamp > new_ent.stamp);
		self.open = !cur.valid || self.gt;
	end

	always_comb begin
		cell_d = cur;
		case (op)
			CELL_PUSH: begin
				if (prev.gt) begin
					cell_d = prev.slot;
				end else if (self.open && !prev.open) begin
					cell_d.valid = 1'b1;
					cell_d.ent   = new_ent;
				end
			end
			CELL_SHL: cell_d = next;
			default:  cell_d = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cell_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= cell_d.ent;
	end

endmodule

// ===== design/tpm_queue.sv =====
// sorted queue as a row of cells, with a parallel stamp compare
`timescale 1ns / 1ps
module tpm_queue import tpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_op_t             op,
	input  entry_t               new_ent,
	input  logic [31:0]          cmp_stamp,
	output entry_t [DEPTH-1:0]   ents,
	output logic   [DEPTH-1:0]   valid,
	output logic   [DEPTH-1:0]   hit
);

	link_t [DEPTH-1:0] links;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		link_t prev;
		cell_t next;
		if (i == 0) begin : g_first
			assign prev = '0;
		end else begin : g_mid
			assign prev = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next = '0;
		end else begin : g_nxt
			assign next = links[i+1].slot;
		end
		tpm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.new_ent (new_ent),
			.prev    (prev),
			.next    (next),
			.self    (links[i])
		);
		assign ents[i]  = links[i].slot.ent;
		assign valid[i] = links[i].slot.valid;
		assign hit[i]   = links[i].slot.valid && (links[i].slot.ent.stamp == cmp_stamp);
	end

endmodule

// ===== design/timestamp_pair_matcher.sv =====
// top level: two sorted timestamp queues and the pair search sequencer
`timescale 1ns / 1ps
// usage
// - slave channel s_*: one beat per operation; s_tuser holds the operation
//   (push to queue a, push to queue b, match tick), s_tdata the stamp and payload
// - master channel m_*: at most one result beat per operation; m_tuser holds
//   kind and drop queue, m_tdata the a and b stamps and payloads
// - each queue is a row of DEPTH cells kept sorted; a push inserts by each
//   cell either holding, taking the new entry or taking its left neighbour
// - a drop (queue full) is put in the output register at the accepting edge
// - a tick walks queue a one entry per cycle against all of queue b in parallel,
//   so it searches up to DEPTH entries of queue a, then left-shifts both queues
//   to discard the entries through the matched pair
// - the next beat is taken only once the sequencer is idle and the output
//   register is empty or being emptied in the same cycle
// - reset clears all valid bits, the output valid flag included; cell contents
//   and the output register's data are left as they are
// - a stalled receiver holds the result in the output register and blocks
//   further input until it is taken
module timestamp_pair_matcher import tpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // stamp[31:0], payload[63:32]
	input  logic [1:0]   s_tuser,   // operation[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // stamp_a, data_a, stamp_b, data_b
	output logic [1:0]   m_tuser    // kind[0], drop_queue[1]
);

	state_t state_q, state_d;
	idx_t   idx_q, idx_d;
	cnt_t   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;

	logic         out_valid_q;
	logic [1:0]   out_user_q;
	logic [127:0] out_data_q;
	logic         load_out;
	logic [1:0]   load_user;
	logic [127:0] load_data;

	cell_op_t op_a, op_b;
	entry_t   new_ent;
	entry_t [DEPTH-1:0] ents_a, ents_b;
	logic   [DEPTH-1:0] valid_a, valid_b, hit_b, hit_m;
	entry_t cur_a, sel_b;
	logic   found;
	idx_t   ib;
	logic   multi;
	logic   accept;
	op_t    op_in;

	assign new_ent  = '{stamp: s_tdata[31:0], data: s_tdata[63:32]};
	assign op_in    = op_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign multi    = valid_a[1] && valid_b[1];

	// queue a entry under search, compared against all of queue b
	assign cur_a = ents_a[idx_q];

	tpm_queue u_qa (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_a),
		.new_ent   (new_ent),
		.cmp_stamp (32'd0),
		.ents      (ents_a),
		.valid     (valid_a),
		.hit       ()
	);

	tpm_queue u_qb (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_b),
		.new_ent   (new_ent),
		.cmp_stamp (cur_a.stamp),
		.ents      (ents_b),
		.valid     (valid_b),
		.hit       (hit_b)
	);

	// with a single entry on either side only the heads may pair
	assign hit_m = multi ? hit_b : (hit_b & {{(DEPTH-1){1'b0}}, 1'b1});

	always_comb begin
		found = 1'b0;
		ib    = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_m[i]) begin
				found = 1'b1;
				ib    = idx_t'(i);
			end
		end
	end

	assign sel_b = ents_b[ib];

	// next state
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_in == OP_TICK) begin
					state_d = ST_SEARCH;
					idx_d   = '0;
				end
			end
			ST_SEARCH: begin
				if (!valid_a[0] || !valid_b[0] || !valid_a[idx_q]
				    || (idx_q != '0 && !multi)) begin
					state_d = ST_IDLE;
				end else if (found) begin
					state_d = ST_SHIFT;
					cnt_a_d = cnt_t'(idx_q) + cnt_t'(1);
					cnt_b_d = cnt_t'(ib) + cnt_t'(1);
				end else if (idx_q == idx_t'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + idx_t'(1);
				end
			end
			ST_SHIFT: begin
				if (cnt_a_q != '0) cnt_a_d = cnt_a_q - cnt_t'(1);
				if (cnt_b_q != '0) cnt_b_d = cnt_b_q - cnt_t'(1);
				if (cnt_a_q <= cnt_t'(1) && cnt_b_q <= cnt_t'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		op_a      = CELL_HOLD;
		op_b      = CELL_HOLD;
		load_out  = 1'b0;
		load_user = '0;
		load_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_in == OP_PUSH_A) begin
					if (valid_a[DEPTH-1]) begin
						load_out  = 1'b1;
						load_user = 2'b01;
						load_data = {64'd0, s_tdata};
					end else begin
						op_a = CELL_PUSH;
					end
				end else if (accept && op_in == OP_PUSH_B) begin
					if (valid_b[DEPTH-1]) begin
						load_out  = 1'b1;
						load_user = 2'b11;
						load_data = {64'd0, s_tdata};
					end else begin
						op_b = CELL_PUSH;
					end
				end
			end
			ST_SEARCH: begin
				if (valid_a[0] && valid_b[0] && valid_a[idx_q]
				    && !(idx_q != '0 && !multi) && found) begin
					load_out  = 1'b1;
					load_user = 2'b00;
					load_data = {sel_b.data, sel_b.stamp, cur_a.data, cur_a.stamp};
				end
			end
			ST_SHIFT: begin
				if (cnt_a_q != '0) op_a = CELL_SHL;
				if (cnt_b_q != '0) op_b = CELL_SHL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_user_q <= load_user;
			out_data_q <= load_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	// input is only taken while the sequencer is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input taken while sequencer busy");

	// a shift phase always has entries left to discard
	a_shift_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> (cnt_a_q != '0 || cnt_b_q != '0))
		else $error("shift phase with nothing to discard");

	// valid cells stay packed from the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(((valid_a + 1'b1) & valid_a) == '0) && (((valid_b + 1'b1) & valid_b) == '0))
		else $error("queue cells not contiguous");

	// a drop result carries no b side
	a_drop_b: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[127:64] == '0)
		else $error("drop result with b fields set");

endmodule
